/* rtl/wavhc_pkg.sv */
// wavhc_pkg: shared types and constants of the wav header check and pcm unpack block
// no dependencies; imported by wavhc_hdr, wav_header_check_pcm_unpack and tb_top
package wavhc_pkg;

  localparam int unsigned HdrBytes = 44;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CfgW     = 31;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [CfgW-1:0] FileSizeRst = 31'd44;
  localparam logic [CfgW-1:0] ReqRateRst  = 31'd16000;

  typedef enum logic [0:0] {
    CfgFileSize = 1'b0,
    CfgReqRate  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindSample = 2'd0,
    KindAccept = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ErrRiff      = 4'd0,
    ErrChunkSize = 4'd1,
    ErrWave      = 4'd2,
    ErrFmt       = 4'd3,
    ErrFmtSize   = 4'd4,
    ErrFormat    = 4'd5,
    ErrByteRate  = 4'd6,
    ErrAlign     = 4'd7,
    ErrData      = 4'd8,
    ErrDataSize  = 4'd9,
    ErrChannels  = 4'd10,
    ErrRate      = 4'd11,
    ErrBits      = 4'd12
  } err_e;

  typedef struct packed {
    logic       in_hdr;
    logic       fire;
    logic       is_err;
    err_e       code;
    logic [5:0] width;
  } hdr_res_t;

endpackage

/* rtl/wavhc_hdr.sv */
// wavhc_hdr: 44-byte riff/wave header parser with per-field checks
// depends on wavhc_pkg
module wavhc_hdr (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [7:0]                  byte_i,
  input  logic [wavhc_pkg::CfgW-1:0]  file_size_i,
  input  logic [wavhc_pkg::CfgW-1:0]  req_rate_i,
  output wavhc_pkg::hdr_res_t         res_o,
  output logic [5:0]                  bits_o
);
  import wavhc_pkg::*;

  localparam logic [PosW-1:0] PosRiff     = 6'd3;
  localparam logic [PosW-1:0] PosChunk    = 6'd7;
  localparam logic [PosW-1:0] PosWave     = 6'd11;
  localparam logic [PosW-1:0] PosFmt      = 6'd15;
  localparam logic [PosW-1:0] PosFmtSize  = 6'd19;
  localparam logic [PosW-1:0] PosFormat   = 6'd21;
  localparam logic [PosW-1:0] PosChannels = 6'd23;
  localparam logic [PosW-1:0] PosRate     = 6'd27;
  localparam logic [PosW-1:0] PosByteRate = 6'd31;
  localparam logic [PosW-1:0] PosAlign    = 6'd35;
  localparam logic [PosW-1:0] PosData     = 6'd39;
  localparam logic [PosW-1:0] PosDataSize = 6'd43;

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     shift_q, shift_d;
  logic [31:0]     rate_q, rate_d;
  logic [31:0]     brate_q, brate_d;
  logic [15:0]     chan_q, chan_d;
  logic [15:0]     bits_q, bits_d;

  logic               in_hdr;
  logic [31:0]        f;
  logic               chunk_ok, dsize_ok, brate_ok, align_ok, rate_ok, bits_ok;
  logic signed [47:0] prod, prod_adj, quot;
  logic signed [16:0] bits_s, bits_adj, bits_q8;
  logic signed [16:0] align_s;

  assign in_hdr = (pos_q < PosW'(HdrBytes));
  assign f      = {byte_i, shift_q[31:8]};

  assign chunk_ok = ({f[31], f} == ({2'b00, file_size_i} - 33'd8));
  assign dsize_ok = ({f[31], f} == ({2'b00, file_size_i} - 33'd44));

  // byte rate against rate * bits / 8, truncating toward zero
  assign prod     = $signed(rate_q) * $signed(f[31:16]);
  assign prod_adj = prod + (prod[47] ? 48'sd7 : 48'sd0);
  assign quot     = prod_adj >>> 3;
  assign brate_ok = ({{16{brate_q[31]}}, brate_q} == quot);

  assign bits_s   = {f[31], f[31:16]};
  assign bits_adj = bits_s + (bits_s[16] ? 17'sd7 : 17'sd0);
  assign bits_q8  = bits_adj >>> 3;
  assign align_s  = {f[15], f[15:0]};
  assign align_ok = (align_s == bits_q8);

  assign rate_ok = !rate_q[31] && (rate_q[30:0] == req_rate_i);
  assign bits_ok = (bits_q == 16'd8) || (bits_q == 16'd16) || (bits_q == 16'd32);

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    rate_d  = rate_q;
    brate_d = brate_q;
    chan_d  = chan_q;
    bits_d  = bits_q;
    res_o        = '0;
    res_o.in_hdr = in_hdr;
    res_o.code   = ErrRiff;
    if (byte_valid_i && in_hdr) begin
      pos_d   = pos_q + 1'b1;
      shift_d = f;
      unique case (pos_q)
        PosRiff: begin
          if (f != TagRiff) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrRiff;
          end
        end
        PosChunk: begin
          if (!chunk_ok) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrChunkSize;
          end
        end
        PosWave: begin
          if (f != TagWave) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrWave;
          end
        end
        PosFmt: begin
          if (f != TagFmt) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrFmt;
          end
        end
        PosFmtSize: begin
          if (f != 32'd16) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrFmtSize;
          end
        end
        PosFormat: begin
          if (f[31:16] != 16'd1) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrFormat;
          end
        end
        PosChannels: chan_d  = f[31:16];
        PosRate:     rate_d  = f;
        PosByteRate: brate_d = f;
        PosAlign: begin
          bits_d = f[31:16];
          if (!brate_ok) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrByteRate;
          end else if (!align_ok) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrAlign;
          end
        end
        PosData: begin
          if (f != TagData) begin
            res_o.fire = 1'b1; res_o.is_err = 1'b1; res_o.code = ErrData;
          end
        end
        PosDataSize: begin
          res_o.fire = 1'b1;
          res_o.is_err = 1'b1;
          if (!dsize_ok) begin
            res_o.code = ErrDataSize;
          end else if (chan_q != 16'd1) begin
            res_o.code = ErrChannels;
          end else if (!rate_ok) begin
            res_o.code = ErrRate;
          end else if (!bits_ok) begin
            res_o.code = ErrBits;
          end else begin
            res_o.is_err = 1'b0;
            res_o.width  = bits_q[5:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign bits_o = bits_q[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      shift_q <= '0;
      rate_q  <= '0;
      brate_q <= '0;
      chan_q  <= '0;
      bits_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      shift_q <= shift_d;
      rate_q  <= rate_d;
      brate_q <= brate_d;
      chan_q  <= chan_d;
      bits_q  <= bits_d;
    end
  end

endmodule

/* rtl/wav_header_check_pcm_unpack.sv */
// wav_header_check_pcm_unpack: top level, wav header check and pcm sample unpack
// depends on wavhc_pkg and wavhc_hdr
//
// usage
// - s_axis carries the file one byte per transaction, in file order
// - the first 44 bytes are the riff/wave header; fields are checked as they complete
//   (byte rate with align, channels/rate/bits last); the last byte gives accept or error
// - after an error every byte is taken and dropped until reset
// - after accept, data bytes are packed into signed little-endian samples of
//   8, 16 or 32 bits; each complete sample yields one result
// - m_axis carries results: tuser is the kind, tdata the sample, error code
//   and sample width
// - cfg port writes file size (index 0) and required rate (index 1) while idle
// throughput and latency
// - one byte per cycle when not stalled; a result shows in the cycle after its byte
// - the output register frees s_axis_tready whenever it is empty or being taken,
//   so a stalled receiver holds the result and stops input only while it waits
// - reset clears the header position, parsed fields, error flag and sample
//   assembly; config returns to file size 44 and rate 16000
module wav_header_check_pcm_unpack (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [wavhc_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // [31:0] sample, [35:32] error_code,
                                                     // [41:36] sample_width, zero fill
  output logic [1:0]                 m_axis_tuser    // [1:0] kind
);
  import wavhc_pkg::*;

  logic [CfgW-1:0] file_size_q, req_rate_q;
  logic            stop_q, stop_d;
  logic [23:0]     part_q, part_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  kind_e           kind_q, kind_d;
  logic [31:0]     sample_q, sample_d;
  err_e            code_q, code_d;
  logic [5:0]      width_q, width_d;

  logic       accept, proceed;
  hdr_res_t   hdr;
  logic [5:0] bits;
  logic [7:0] b;
  logic [23:0] ins;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign proceed       = accept && !stop_q;
  assign b             = s_axis_tdata;

  wavhc_hdr u_hdr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (proceed),
    .byte_i       (b),
    .file_size_i  (file_size_q),
    .req_rate_i   (req_rate_q),
    .res_o        (hdr),
    .bits_o       (bits)
  );

  assign ins = {16'b0, b} << {cnt_q, 3'b000};

  always_comb begin
    stop_d   = stop_q;
    part_d   = part_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    kind_d   = kind_q;
    sample_d = sample_q;
    code_d   = code_q;
    width_d  = width_q;
    if (proceed && hdr.in_hdr) begin
      if (hdr.fire) begin
        ovalid_d = 1'b1;
        sample_d = '0;
        if (hdr.is_err) begin
          stop_d  = 1'b1;
          kind_d  = KindError;
          code_d  = hdr.code;
          width_d = '0;
        end else begin
          kind_d  = KindAccept;
          code_d  = ErrRiff;
          width_d = hdr.width;
        end
      end
    end else if (proceed) begin
      priority if (bits == 6'd8) begin
        ovalid_d = 1'b1;
        sample_d = {{24{b[7]}}, b};
      end else if (bits == 6'd16) begin
        if (cnt_q == 2'd0) begin
          part_d = {16'b0, b};
          cnt_d  = 2'd1;
        end else begin
          ovalid_d = 1'b1;
          sample_d = {{16{b[7]}}, b, part_q[7:0]};
        end
      end else begin
        if (cnt_q != 2'd3) begin
          part_d = part_q | ins;
          cnt_d  = cnt_q + 2'd1;
        end else begin
          ovalid_d = 1'b1;
          sample_d = {b, part_q};
        end
      end
      if (ovalid_d && !(ovalid_q && !m_axis_tready)) begin
        part_d  = '0;
        cnt_d   = '0;
        kind_d  = KindSample;
        code_d  = ErrRiff;
        width_d = bits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= FileSizeRst;
      req_rate_q  <= ReqRateRst;
      stop_q      <= 1'b0;
      part_q      <= '0;
      cnt_q       <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgFileSize: file_size_q <= cfg_wdata_i;
          CfgReqRate:  req_rate_q  <= cfg_wdata_i;
        endcase
      end
      stop_q   <= stop_d;
      part_q   <= part_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    sample_q <= sample_d;
    code_q   <= code_d;
    width_q  <= width_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {6'b0, width_q, code_q, sample_q};

`ifndef SYNTH
  a_err_silences: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (kind_q == KindError) |=> !m_axis_tvalid)
    else $error("result after header error");

  a_no_sample_before_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind_q != KindSample) |-> (sample_q == 32'd0))
    else $error("nonzero sample on status result");

  a_err_width_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind_q == KindError) |-> (width_q == 6'd0) && stop_q)
    else $error("error result without stop or with width");

  a_sample_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind_q == KindSample) |->
      (width_q == 6'd8) || (width_q == 6'd16) || (width_q == 6'd32))
    else $error("sample with bad width");
`endif

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking testbench for wav_header_check_pcm_unpack
// streams one wav file (header, possibly flawed, then pcm data) and checks every result
// depends on wavhc_pkg and the block under test
module tb_top;
  import wavhc_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned ItemTarget = 1750;
  localparam logic [CfgW-1:0] CfgMax = 31'h7FFF_FFFF;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] sample;
    err_e        code;
    logic [5:0]  width;
  } wav_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // parser state as the block should hold it
  logic [CfgW-1:0] cfg_fsize = FileSizeRst;
  logic [CfgW-1:0] cfg_rate  = ReqRateRst;
  int unsigned hdr_pos = 0;
  logic [31:0] fld     = '0;
  logic [31:0] rate_q  = '0;
  logic [31:0] brate_q = '0;
  logic [15:0] chans_q = '0;
  logic [15:0] bits_q  = '0;
  bit          halted  = 1'b0;
  logic [23:0] part_q  = '0;
  logic [1:0]  part_cnt = '0;

  wav_result_t due_results[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;

  // the file being sent
  logic [7:0]      hdr_bytes [HdrBytes];
  logic [15:0]     plan_bits;
  logic [31:0]     plan_rate;
  logic [CfgW-1:0] plan_fsize;
  bit              flawed;
  err_e            flaw;

  always #4 clk_i = ~clk_i;

  wav_header_check_pcm_unpack u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic bit halt_on(input err_e e, output wav_result_t r);
    halted = 1'b1;
    r = '{kind: KindError, sample: 32'd0, code: e, width: 6'd0};
    return 1'b1;
  endfunction

  // advances the parser by one file byte; returns 1 when the byte yields a result
  function automatic bit decode_byte(input logic [7:0] b, output wav_result_t r);
    int unsigned at;
    longint bits_s;
    logic [31:0] s;
    r = '{kind: KindSample, sample: 32'd0, code: ErrRiff, width: 6'd0};
    if (halted) return 1'b0;
    if (hdr_pos < HdrBytes) begin
      at = hdr_pos;
      fld = {b, fld[31:8]};
      hdr_pos++;
      case (at)
        3:  if (fld != TagRiff) return halt_on(ErrRiff, r);
        7:  if (longint'($signed(fld)) != longint'(cfg_fsize) - 8) return halt_on(ErrChunkSize, r);
        11: if (fld != TagWave) return halt_on(ErrWave, r);
        15: if (fld != TagFmt) return halt_on(ErrFmt, r);
        19: if (fld != 32'd16) return halt_on(ErrFmtSize, r);
        21: if ($signed(fld[31:16]) != 16'sd1) return halt_on(ErrFormat, r);
        23: chans_q = fld[31:16];
        27: rate_q = fld;
        31: brate_q = fld;
        35: begin
          bits_s = longint'($signed(fld[31:16]));
          if (longint'($signed(brate_q)) != longint'($signed(rate_q)) * bits_s / 8)
            return halt_on(ErrByteRate, r);
          if (longint'($signed(fld[15:0])) != bits_s / 8) return halt_on(ErrAlign, r);
          bits_q = fld[31:16];
        end
        39: if (fld != TagData) return halt_on(ErrData, r);
        43: begin
          if (longint'($signed(fld)) != longint'(cfg_fsize) - 44) return halt_on(ErrDataSize, r);
          if (chans_q != 16'd1) return halt_on(ErrChannels, r);
          if (longint'($signed(rate_q)) != longint'(cfg_rate)) return halt_on(ErrRate, r);
          if (bits_q != 16'd8 && bits_q != 16'd16 && bits_q != 16'd32)
            return halt_on(ErrBits, r);
          r.kind  = KindAccept;
          r.width = bits_q[5:0];
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    if (bits_q == 16'd8) begin
      s = {{24{b[7]}}, b};
    end else if (bits_q == 16'd16) begin
      if (part_cnt == 2'd0) begin
        part_q   = {16'd0, b};
        part_cnt = 2'd1;
        return 1'b0;
      end
      s = {{16{b[7]}}, b, part_q[7:0]};
    end else begin
      if (part_cnt < 2'd3) begin
        part_q[8*part_cnt +: 8] = b;
        part_cnt++;
        return 1'b0;
      end
      s = {b, part_q};
    end
    part_q   = '0;
    part_cnt = '0;
    r.sample = s;
    r.width  = bits_q[5:0];
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    wav_result_t r;
    if (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (decode_byte(b, r)) due_results.push_back(r);
    n_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CfgFileSize: cfg_fsize = v;
      CfgReqRate:  cfg_rate  = v;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop input and drain all pending results, then idle so the pipeline clears
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_le(input int unsigned at, input logic [31:0] v, input int unsigned n);
    for (int unsigned k = 0; k < n; k++) hdr_bytes[at + k] = v[8*k +: 8];
  endtask

  task automatic test_config_sweep();
    longint rate_max;
    case ($urandom_range(2))
      0:       plan_bits = 16'd8;
      1:       plan_bits = 16'd16;
      default: plan_bits = 16'd32;
    endcase
    flawed = ($urandom_range(4) == 0);
    flaw   = err_e'($urandom_range(int'(ErrBits)));
    // highest rate whose byte rate still fits in 32 signed bits
    rate_max = (longint'(CfgMax) * 8) / plan_bits;
    if (flawed && flaw == ErrBits) rate_max = 100000;
    case ($urandom_range(3))
      0:       plan_rate = 32'd0;
      1:       plan_rate = 32'(rate_max);
      2:       plan_rate = 32'd16000;
      default: plan_rate = $urandom_range(32'(rate_max));
    endcase
    case ($urandom_range(2))
      0:       plan_fsize = 31'd44;
      1:       plan_fsize = CfgMax;
      default: plan_fsize = 31'd44 + 31'($urandom_range(100000));
    endcase
    write_reg(CfgFileSize, CfgMax);
    write_reg(CfgReqRate, '0);
    write_reg(CfgFileSize, 31'd44);
    write_reg(CfgReqRate, CfgMax);
    write_reg(CfgFileSize, plan_fsize);
    if (flawed && flaw == ErrRate)
      write_reg(CfgReqRate, plan_rate[CfgW-1:0] ^ (31'd1 << $urandom_range(CfgW - 1)));
    else
      write_reg(CfgReqRate, plan_rate[CfgW-1:0]);
  endtask

  task automatic test_header();
    int unsigned at, len, r;
    logic [15:0] bits16;
    longint brate;
    bits16 = plan_bits;
    if (flawed && flaw == ErrBits) begin
      case ($urandom_range(4))
        0:       bits16 = 16'd0;
        1:       bits16 = 16'd24;
        2:       bits16 = 16'hFFF8;
        3:       bits16 = 16'd4;
        default: bits16 = 16'($urandom);
      endcase
    end
    brate = longint'($signed(plan_rate)) * longint'($signed(bits16)) / 8;
    put_le(0, TagRiff, 4);
    put_le(4, {1'b0, plan_fsize} - 32'd8, 4);
    put_le(8, TagWave, 4);
    put_le(12, TagFmt, 4);
    put_le(16, 32'd16, 4);
    put_le(20, 32'd1, 2);
    put_le(22, 32'd1, 2);
    put_le(24, plan_rate, 4);
    put_le(28, 32'(brate), 4);
    put_le(32, 32'(longint'($signed(bits16)) / 8), 2);
    put_le(34, {16'd0, bits16}, 2);
    put_le(36, TagData, 4);
    put_le(40, {1'b0, plan_fsize} - 32'd44, 4);
    if (flawed) begin
      at  = 0;
      len = 4;
      case (flaw)
        ErrRiff:      at = 0;
        ErrChunkSize: at = 4;
        ErrWave:      at = 8;
        ErrFmt:       at = 12;
        ErrFmtSize:   at = 16;
        ErrFormat:    begin at = 20; len = 2; end
        ErrChannels:  begin at = 22; len = 2; end
        ErrByteRate:  at = 28;
        ErrAlign:     begin at = 32; len = 2; end
        ErrData:      at = 36;
        ErrDataSize:  at = 40;
        default:      len = 0;
      endcase
      if (len != 0) begin
        r = $urandom_range(8 * len - 1);
        hdr_bytes[at + r / 8] ^= 8'd1 << (r % 8);
      end
    end
    for (int unsigned i = 0; i < HdrBytes; i++) send_byte(hdr_bytes[i]);
  endtask

  task automatic test_sample_extremes();
    logic [31:0] v;
    int unsigned nb;
    if (halted) return;
    nb = bits_q / 8;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0:       v = '0;
        1:       v = '1;
        2:       v = 32'd1 << (bits_q - 1);
        3:       v = (32'd1 << (bits_q - 1)) - 32'd1;
        default: v = 32'd1;
      endcase
      for (int unsigned k = 0; k < nb; k++) send_byte(v[8*k +: 8]);
    end
  endtask

  // settings only matter to the header; the stream must be unaffected
  task automatic test_config_rewrite();
    settle();
    write_reg(CfgFileSize, 31'd44 + 31'($urandom_range(1000)));
    write_reg(CfgReqRate, '0);
    write_reg(CfgFileSize, CfgMax);
    write_reg(CfgReqRate, CfgMax);
  endtask

  task automatic test_random_stream();
    int unsigned count;
    count = (n_sent < ItemTarget) ? ItemTarget - n_sent : 0;
    for (int unsigned i = 0; i < count; i++) begin
      calm <= (i >= count / 4) && (i < count / 4 + 300);
      send_byte(8'($urandom));
    end
    calm <= 1'b0;
  endtask

  // leave an incomplete sample behind (none for 8-bit samples), which must never come out
  task automatic test_partial_tail();
    if (halted) return;
    while (part_cnt != 2'd0) send_byte(8'($urandom));
    repeat (bits_q / 8 - 1) send_byte(8'($urandom));
  endtask

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 12);

  always @(posedge clk_i) begin : check_results
    wav_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result with no transaction pending: tuser %0d tdata %h",
               m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[31:0] !== want.sample) begin
          $error("sample: expected %0d, got %0d", $signed(want.sample),
                 $signed(m_axis_tdata[31:0]));
          n_errors++;
        end
        if (m_axis_tdata[35:32] !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, m_axis_tdata[35:32]);
          n_errors++;
        end
        if (m_axis_tdata[41:36] !== want.width) begin
          $error("sample_width: expected %0d, got %0d", want.width, m_axis_tdata[41:36]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgFileSize;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_config_sweep();
    test_header();
    test_sample_extremes();
    test_config_rewrite();
    test_random_stream();
    test_partial_tail();
    settle();
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
